// File: rtl/tlcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled label collision placer package
// Shared widths, codes, box type and sequencer states.
// ----------------------------------------------------------------------------
package tlcp_pkg;

    localparam int COORD_W = 13;
    localparam int ANCH_W  = 14;
    localparam int SIZE_W  = 11;
    localparam int FADE_W  = 5;
    localparam int CFG_W   = 13;
    localparam int EXT_W   = 18;

    localparam logic [FADE_W-1:0] FADE_FREE = 5'd20;
    localparam logic [ANCH_W-1:0] GAP_NEG   = 14'd40;
    localparam logic [ANCH_W-1:0] GAP_NEAR  = 14'd20;

    localparam logic [1:0] GRAV_LOW  = 2'd0;
    localparam logic [1:0] GRAV_HIGH = 2'd2;

    typedef enum logic [2:0] {
        STS_PLACED   = 3'd0,
        STS_OUTSIDE  = 3'd1,
        STS_OVERLAP  = 3'd2,
        STS_FULL     = 3'd3,
        STS_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_VP_W     = 3'd2,
        CFG_VP_H     = 3'd3,
        CFG_ALIGN_H  = 3'd4,
        CFG_ALIGN_V  = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SEARCH,
        ST_CHECK,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_BOX_RD,
        ST_BOX_CMP,
        ST_NEXT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] xmin;
        logic [COORD_W-1:0] xmax;
        logic [COORD_W-1:0] ymin;
        logic [COORD_W-1:0] ymax;
    } box_t;

    typedef struct packed {
        logic              overlap;
        logic [FADE_W-1:0] fade;
    } gap_res_t;

endpackage

// File: rtl/tlcp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled label collision placer channels
// Place item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlcp_in_if;
    import tlcp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [ANCH_W-1:0] anchor_x;
    logic signed [ANCH_W-1:0] anchor_y;
    logic [SIZE_W-1:0]        label_width;
    logic [SIZE_W-1:0]        label_height;
    logic                     is_icon;

    modport source (output valid, kind, anchor_x, anchor_y, label_width, label_height,
                    is_icon, input ready);
    modport sink (input valid, kind, anchor_x, anchor_y, label_width, label_height,
                  is_icon, output ready);
endinterface

interface tlcp_out_if;
    import tlcp_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [FADE_W-1:0]  fade;
    logic [COORD_W-1:0] box_xmin;
    logic [COORD_W-1:0] box_xmax;
    logic [COORD_W-1:0] box_ymin;
    logic [COORD_W-1:0] box_ymax;

    modport source (output valid, status, fade, box_xmin, box_xmax, box_ymin, box_ymax,
                    input ready);
    modport sink (input valid, status, fade, box_xmin, box_xmax, box_ymin, box_ymax,
                  output ready);
endinterface

// File: rtl/tlcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/tlcp_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis alignment and clip
// Place one axis of the label by gravity, clip to the viewport, flag culling.
// ----------------------------------------------------------------------------
module tlcp_align (
    input  logic signed [tlcp_pkg::ANCH_W-1:0] anchor,
    input  logic [tlcp_pkg::COORD_W-1:0]       origin,
    input  logic [tlcp_pkg::SIZE_W-1:0]        size,
    input  logic [1:0]                         grav,
    input  logic [tlcp_pkg::COORD_W-1:0]       lim,
    output logic [tlcp_pkg::COORD_W-1:0]       lo,
    output logic [tlcp_pkg::COORD_W-1:0]       hi,
    output logic                               keep
);
    import tlcp_pkg::*;

    logic signed [EXT_W-1:0] diff, a, s, s2, l, h, lc, hc, lims;

    always_comb
    begin
        diff = EXT_W'(anchor) - $signed({{(EXT_W-COORD_W){1'b0}}, origin});
        a    = {diff[EXT_W-2:0], 1'b0};
        s    = $signed({{(EXT_W-SIZE_W){1'b0}}, size});
        s2   = {s[EXT_W-2:0], 1'b0};
        lims = $signed({{(EXT_W-COORD_W){1'b0}}, lim});
        case (grav)
            GRAV_LOW:
            begin
                l = a;
                h = a + s2;
            end
            GRAV_HIGH:
            begin
                l = a - s2;
                h = a;
            end
            default:
            begin
                l = a - s;
                h = a + s;
            end
        endcase
        lc   = (l < 0) ? '0 : l;
        hc   = (h > lims) ? lims : h;
        keep = !((lc > lims) || (hc < 0));
        lo   = lc[COORD_W-1:0];
        hi   = hc[COORD_W-1:0];
    end
endmodule

// File: rtl/tlcp_gap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box gap unit
// Compare one stored box with the new box: overlap flag and updated fade.
// ----------------------------------------------------------------------------
module tlcp_gap (
    input  tlcp_pkg::box_t                  stored,
    input  tlcp_pkg::box_t                  cur,
    input  logic [tlcp_pkg::FADE_W-1:0]     fade_in,
    output tlcp_pkg::gap_res_t              res
);
    import tlcp_pkg::*;

    logic signed [ANCH_W-1:0] d0, d1, d2, d3;
    logic [ANCH_W-1:0] g0, g1, g2, g3, ex, ey;
    logic [FADE_W-1:0] f;

    function automatic logic [ANCH_W-1:0] gap_of(input logic signed [ANCH_W-1:0] d);
        gap_of = (d < 0) ? GAP_NEG : d;
    endfunction

    always_comb
    begin
        d0 = $signed({1'b0, stored.xmin}) - $signed({1'b0, cur.xmax});
        d1 = $signed({1'b0, cur.xmin}) - $signed({1'b0, stored.xmax});
        d2 = $signed({1'b0, stored.ymin}) - $signed({1'b0, cur.ymax});
        d3 = $signed({1'b0, cur.ymin}) - $signed({1'b0, stored.ymax});
        g0 = gap_of(d0);
        g1 = gap_of(d1);
        g2 = gap_of(d2);
        g3 = gap_of(d3);
        ex = (g0 < g1) ? g0 : g1;
        ey = (g2 < g3) ? g2 : g3;
        f  = fade_in;
        if ((ex < GAP_NEAR) && (ey < GAP_NEAR))
        begin
            if (ex[FADE_W-1:0] < f)
            begin
                f = ex[FADE_W-1:0];
            end
            if (ey[FADE_W-1:0] < f)
            begin
                f = ey[FADE_W-1:0];
            end
        end
        res.overlap = (d0 < 0) && (d1 < 0) && (d2 < 0) && (d3 < 0);
        res.fade    = f;
    end
endmodule

// File: rtl/tiled_label_collision_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled label collision placer
// Sequence: a clear item goes straight to the result; a place item culled at
// alignment ends there; other place items run the tile search, scan the boxes
// stored in each touched tile and, if none overlaps and no tile is full, store the new box there.
// Throughput: one item at a time, set by the box RAM read/compare loop.
// Reset: tile counts read as zero through per-tile valid bits, cleared at once.
// ----------------------------------------------------------------------------
module tiled_label_collision_placer #(
    parameter int TILE_SIZE      = 128,
    parameter int TILES_X        = 16,
    parameter int TILES_Y        = 16,
    parameter int BOXES_PER_TILE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tlcp_in_if.sink                       place,
    tlcp_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [tlcp_pkg::CFG_W-1:0]    cfg_data
);
    import tlcp_pkg::*;

    localparam int MAXT = (TILES_X > TILES_Y) ? TILES_X : TILES_Y;
    localparam int TW   = $clog2(MAXT + 2);
    localparam int NT   = TILES_X * TILES_Y;
    localparam int NTW  = (NT > 1) ? $clog2(NT) : 1;
    localparam int NB   = NT * BOXES_PER_TILE;
    localparam int BAW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int CNTW = $clog2(BOXES_PER_TILE + 1);
    localparam int LW   = BAW + NTW + TW + CNTW;
    localparam logic [EXT_W-1:0] SPAN = EXT_W'(2 * TILE_SIZE);

    // configuration
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [11:0]        vp_w_reg, vp_h_reg;
    logic [1:0]         align_h_reg, align_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            vp_w_reg     <= 12'd2048;
            vp_h_reg     <= 12'd2048;
            align_h_reg  <= 2'd1;
            align_v_reg  <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_VP_W:     vp_w_reg     <= cfg_data[11:0];
                CFG_VP_H:     vp_h_reg     <= cfg_data[11:0];
                CFG_ALIGN_H:  align_h_reg  <= cfg_data[1:0];
                CFG_ALIGN_V:  align_v_reg  <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic signed [ANCH_W-1:0] ax_reg, ay_reg, ax_next, ay_next;
    logic [SIZE_W-1:0]  lw_reg, lh_reg, lw_next, lh_next;
    logic               icon_reg, icon_next;
    box_t               cur_reg, cur_next;
    logic [TW-1:0]      c_reg, c_next;
    logic [EXT_W-1:0]   base_reg, base_next;
    logic [5:0]         found_reg, found_next;
    logic [TW-1:0]      nx_reg, ny_reg, tx0_reg, tx1_reg, ty0_reg, ty1_reg;
    logic [TW-1:0]      nx_next, ny_next, tx0_next, tx1_next, ty0_next, ty1_next;
    logic [TW-1:0]      tx_reg, ty_reg, tx_next, ty_next;
    logic [CNTW-1:0]    k_reg, k_next, cnt_reg, cnt_next;
    logic               any_full_reg, any_full_next, wr_phase_reg, wr_phase_next;
    status_t            status_reg, status_next;
    logic [FADE_W-1:0]  fade_reg, fade_next;
    logic [NT-1:0]      valid_reg, valid_next;

    logic               res_valid_reg, res_valid_next;
    status_t            res_status_reg, res_status_next;
    logic [FADE_W-1:0]  res_fade_reg, res_fade_next;
    box_t               res_box_reg, res_box_next;

    logic [COORD_W-1:0] ax0, ax1, ay0, ay1;
    logic               keep_x, keep_y;
    logic [LW-1:0]      t_lin, bread_lin, bwrite_lin;
    logic [NTW-1:0]     t;
    logic [CNTW-1:0]    cnt_q, cnt_eff;
    box_t               box_q;
    gap_res_t           gap;
    logic               cnt_we, box_we;
    logic [TW-1:0]      tx1_sat, ty1_sat;
    logic               cull, empty, last_ty, last_tile, k_last, res_free;

    tlcp_align u_align_x (
        .anchor (ax_reg),
        .origin (origin_x_reg),
        .size   (lw_reg),
        .grav   (icon_reg ? align_h_reg : GRAV_LOW),
        .lim    ({vp_w_reg, 1'b0}),
        .lo     (ax0),
        .hi     (ax1),
        .keep   (keep_x)
    );

    tlcp_align u_align_y (
        .anchor (ay_reg),
        .origin (origin_y_reg),
        .size   (lh_reg),
        .grav   (icon_reg ? align_v_reg : GRAV_LOW),
        .lim    ({vp_h_reg, 1'b0}),
        .lo     (ay0),
        .hi     (ay1),
        .keep   (keep_y)
    );

    tlcp_gap u_gap (
        .stored  (box_q),
        .cur     (cur_reg),
        .fade_in (fade_reg),
        .res     (gap)
    );

    assign t_lin      = LW'(ty_reg) * LW'(TILES_X) + LW'(tx_reg);
    assign t          = t_lin[NTW-1:0];
    assign bread_lin  = LW'(t) * LW'(BOXES_PER_TILE) + LW'(k_reg);
    assign bwrite_lin = LW'(t) * LW'(BOXES_PER_TILE) + LW'(cnt_eff);
    assign cnt_eff    = valid_reg[t] ? cnt_q : '0;
    assign cnt_we     = (state_reg == ST_CNT_WAIT) && wr_phase_reg;
    assign box_we     = cnt_we;

    tlcp_ram #(.WIDTH(CNTW), .DEPTH(NT)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (t),
        .wdata (cnt_eff + CNTW'(1)),
        .raddr (t),
        .rdata (cnt_q)
    );

    tlcp_ram #(.WIDTH($bits(box_t)), .DEPTH(NB)) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (bwrite_lin[BAW-1:0]),
        .wdata (cur_reg),
        .raddr (bread_lin[BAW-1:0]),
        .rdata (box_q)
    );

    assign tx1_sat   = (tx1_reg >= nx_reg) ? nx_reg - TW'(1) : tx1_reg;
    assign ty1_sat   = (ty1_reg >= ny_reg) ? ny_reg - TW'(1) : ty1_reg;
    assign cull      = (tx0_reg > nx_reg) || (ty0_reg > ny_reg);
    assign empty     = (tx1_sat < tx0_reg) || (ty1_sat < ty0_reg);
    assign last_ty   = (ty_reg == ty1_reg);
    assign last_tile = last_ty && (tx_reg == tx1_reg);
    assign k_last    = ((CNTW + 1)'(k_reg) + (CNTW + 1)'(1)) == (CNTW + 1)'(cnt_reg);
    assign res_free  = !res_valid_reg || result.ready;

    assign place.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (place.valid)
                begin
                    state_next = place.kind ? ST_FIN : ST_ALIGN;
                end
            end
            ST_ALIGN:    state_next = (keep_x && keep_y) ? ST_SEARCH : ST_FIN;
            ST_SEARCH:   state_next = (c_reg == TW'(MAXT)) ? ST_CHECK : ST_SEARCH;
            ST_CHECK:    state_next = (cull || empty) ? ST_FIN : ST_CNT_RD;
            ST_CNT_RD:   state_next = ST_CNT_WAIT;
            ST_CNT_WAIT:
            begin
                if (wr_phase_reg || (cnt_eff == '0))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_BOX_RD;
                end
            end
            ST_BOX_RD:   state_next = ST_BOX_CMP;
            ST_BOX_CMP:
            begin
                if (gap.overlap)
                begin
                    state_next = ST_FIN;
                end
                else if (k_last)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_BOX_RD;
                end
            end
            ST_NEXT:
            begin
                if (last_tile && (wr_phase_reg || any_full_reg))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_FIN:      state_next = res_free ? ST_IDLE : ST_FIN;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        lw_next        = lw_reg;
        lh_next        = lh_reg;
        icon_next      = icon_reg;
        cur_next       = cur_reg;
        c_next         = c_reg;
        base_next      = base_reg;
        found_next     = found_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        tx0_next       = tx0_reg;
        tx1_next       = tx1_reg;
        ty0_next       = ty0_reg;
        ty1_next       = ty1_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        any_full_next  = any_full_reg;
        wr_phase_next  = wr_phase_reg;
        status_next    = status_reg;
        fade_next      = fade_reg;
        valid_next     = valid_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_status_next = res_status_reg;
        res_fade_next  = res_fade_reg;
        res_box_next   = res_box_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (place.valid)
                begin
                    ax_next   = place.anchor_x;
                    ay_next   = place.anchor_y;
                    lw_next   = place.label_width;
                    lh_next   = place.label_height;
                    icon_next = place.is_icon;
                    fade_next = '0;
                    if (place.kind)
                    begin
                        valid_next  = '0;
                        status_next = STS_CLEARED;
                    end
                end
            end
            ST_ALIGN:
            begin
                cur_next    = '{xmin: ax0, xmax: ax1, ymin: ay0, ymax: ay1};
                status_next = STS_OUTSIDE;
                c_next      = '0;
                base_next   = '0;
                found_next  = '0;
                nx_next     = TW'(TILES_X);
                ny_next     = TW'(TILES_Y);
                tx0_next    = TW'(MAXT + 1);
                tx1_next    = TW'(MAXT + 1);
                ty0_next    = TW'(MAXT + 1);
                ty1_next    = TW'(MAXT + 1);
            end
            ST_SEARCH:
            begin
                if (!found_reg[0] && (c_reg != '0) && (c_reg <= TW'(TILES_X)) &&
                    (base_reg >= EXT_W'({vp_w_reg, 1'b0})))
                begin
                    nx_next       = c_reg;
                    found_next[0] = 1'b1;
                end
                if (!found_reg[1] && (c_reg != '0) && (c_reg <= TW'(TILES_Y)) &&
                    (base_reg >= EXT_W'({vp_h_reg, 1'b0})))
                begin
                    ny_next       = c_reg;
                    found_next[1] = 1'b1;
                end
                if (!found_reg[2] && ((base_reg + SPAN) > EXT_W'(cur_reg.xmin)))
                begin
                    tx0_next      = c_reg;
                    found_next[2] = 1'b1;
                end
                if (!found_reg[3] && (base_reg >= EXT_W'(cur_reg.xmax)))
                begin
                    tx1_next      = c_reg;
                    found_next[3] = 1'b1;
                end
                if (!found_reg[4] && ((base_reg + SPAN) > EXT_W'(cur_reg.ymin)))
                begin
                    ty0_next      = c_reg;
                    found_next[4] = 1'b1;
                end
                if (!found_reg[5] && (base_reg >= EXT_W'(cur_reg.ymax)))
                begin
                    ty1_next      = c_reg;
                    found_next[5] = 1'b1;
                end
                c_next    = c_reg + TW'(1);
                base_next = base_reg + SPAN;
            end
            ST_CHECK:
            begin
                tx1_next      = tx1_sat;
                ty1_next      = ty1_sat;
                tx_next       = tx0_reg;
                ty_next       = ty0_reg;
                any_full_next = 1'b0;
                wr_phase_next = 1'b0;
                if (!cull)
                begin
                    status_next = STS_PLACED;
                    fade_next   = FADE_FREE;
                end
            end
            ST_CNT_RD:   ;
            ST_CNT_WAIT:
            begin
                cnt_next = cnt_eff;
                k_next   = '0;
                if ((CNTW + 1)'(cnt_eff) >= (CNTW + 1)'(BOXES_PER_TILE))
                begin
                    any_full_next = 1'b1;
                end
                if (wr_phase_reg)
                begin
                    valid_next[t] = 1'b1;
                end
            end
            ST_BOX_RD:   ;
            ST_BOX_CMP:
            begin
                k_next = k_reg + CNTW'(1);
                if (gap.overlap)
                begin
                    status_next = STS_OVERLAP;
                    fade_next   = '0;
                end
                else
                begin
                    fade_next = gap.fade;
                end
            end
            ST_NEXT:
            begin
                if (last_tile)
                begin
                    tx_next = tx0_reg;
                    ty_next = ty0_reg;
                    if (!wr_phase_reg)
                    begin
                        if (any_full_reg)
                        begin
                            status_next = STS_FULL;
                            fade_next   = '0;
                        end
                        else
                        begin
                            wr_phase_next = 1'b1;
                        end
                    end
                end
                else if (last_ty)
                begin
                    ty_next = ty0_reg;
                    tx_next = tx_reg + TW'(1);
                end
                else
                begin
                    ty_next = ty_reg + TW'(1);
                end
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_fade_next   = fade_reg;
                    if ((status_reg == STS_OUTSIDE) || (status_reg == STS_CLEARED))
                    begin
                        res_box_next = '0;
                    end
                    else
                    begin
                        res_box_next = cur_reg;
                    end
                end
            end
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            found_reg     <= '0;
            c_reg         <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            k_reg         <= '0;
            any_full_reg  <= 1'b0;
            wr_phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            found_reg     <= found_next;
            c_reg         <= c_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            k_reg         <= k_next;
            any_full_reg  <= any_full_next;
            wr_phase_reg  <= wr_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        lw_reg         <= lw_next;
        lh_reg         <= lh_next;
        icon_reg       <= icon_next;
        cur_reg        <= cur_next;
        base_reg       <= base_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        tx0_reg        <= tx0_next;
        tx1_reg        <= tx1_next;
        ty0_reg        <= ty0_next;
        ty1_reg        <= ty1_next;
        cnt_reg        <= cnt_next;
        status_reg     <= status_next;
        fade_reg       <= fade_next;
        res_status_reg <= res_status_next;
        res_fade_reg   <= res_fade_next;
        res_box_reg    <= res_box_next;
    end

    assign result.valid    = res_valid_reg;
    assign result.status   = res_status_reg;
    assign result.fade     = res_fade_reg;
    assign result.box_xmin = res_box_reg.xmin;
    assign result.box_xmax = res_box_reg.xmax;
    assign result.box_ymin = res_box_reg.ymin;
    assign result.box_ymax = res_box_reg.ymax;

    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.fade <= FADE_FREE)
        else $error("fade above free value");

    a_reject_fade: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != STS_PLACED)) |-> (result.fade == '0))
        else $error("rejected item with non-zero fade");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && ((result.status == STS_OUTSIDE) || (result.status == STS_CLEARED)))
        |-> ((result.box_xmin == '0) && (result.box_xmax == '0) &&
             (result.box_ymin == '0) && (result.box_ymax == '0)))
        else $error("box reported for culled or clear item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT_WAIT) |->
        ((CNTW + 1)'(cnt_eff) <= (CNTW + 1)'(BOXES_PER_TILE)))
        else $error("tile count beyond capacity");

endmodule

// File: dv/tb_tiled_label_collision_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled label collision placer testbench
// Drives place and clear items through the valid/ready channels under several
// idling phases and configurations, predicts every result item from a local
// tile/box model and compares each field in order of arrival.
// ----------------------------------------------------------------------------
module tb_tiled_label_collision_placer;
    import tlcp_pkg::*;

    localparam int TSIZE = 128;
    localparam int NTX   = 16;
    localparam int NTY   = 16;
    localparam int NBOX  = 16;

    typedef struct packed {
        logic              kind;
        logic [ANCH_W-1:0] ax;
        logic [ANCH_W-1:0] ay;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic              icon;
    } label_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [FADE_W-1:0]  fade;
        logic [COORD_W-1:0] xmin;
        logic [COORD_W-1:0] xmax;
        logic [COORD_W-1:0] ymin;
        logic [COORD_W-1:0] ymax;
    } placement_t;

    typedef struct {
        label_req_t req;
        logic       has_exp;
        placement_t exp;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    tlcp_in_if  place ();
    tlcp_out_if result ();

    tiled_label_collision_placer DUT (
        .clk(clk), .rst_n(rst_n), .place(place), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    int org_x, org_y, vp_w, vp_h, grav_h, grav_v;
    int box_x0 [NTX*NTY][NBOX];
    int box_x1 [NTX*NTY][NBOX];
    int box_y0 [NTX*NTY][NBOX];
    int box_y1 [NTX*NTY][NBOX];
    int occupancy [NTX*NTY];

    placement_t pending_q [$];
    placement_t forced_q [$];
    logic       forced_valid_q [$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1000ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int tiles_of(int vsize, int maxt);
        int n;
        n = (vsize + TSIZE - 1) / TSIZE;
        if (n > maxt) n = maxt;
        if (n < 1) n = 1;
        return n;
    endfunction

    function automatic bit fit_axis(int a, int size, int grav, int lim,
                                    output int lo, output int hi);
        if (grav == GRAV_LOW)
        begin
            lo = a;
            hi = a + 2 * size;
        end
        else if (grav == GRAV_HIGH)
        begin
            lo = a - 2 * size;
            hi = a;
        end
        else
        begin
            lo = a - size;
            hi = a + size;
        end
        if (lo < 0) lo = 0;
        if (hi > lim) hi = lim;
        return !(lo > lim || hi < 0);
    endfunction

    function automatic int gap_of(int d);
        return d < 0 ? 40 : d;
    endfunction

    function automatic placement_t place_label(label_req_t r);
        placement_t p;
        int ax, ay, x0, x1, y0, y1, nx, ny, tx0, tx1, ty0, ty1, fd, t;
        int d0, d1, d2, d3;
        int ex, ey, gh, gv;
        bit ok;
        p = '0;
        if (r.kind)
        begin
            foreach (occupancy[i]) occupancy[i] = 0;
            p.status = STS_CLEARED;
            return p;
        end
        ax = 2 * ($signed(r.ax) - org_x);
        ay = 2 * ($signed(r.ay) - org_y);
        gh = r.icon ? grav_h : 0;
        gv = r.icon ? grav_v : 0;
        ok = fit_axis(ax, int'(r.w), gh, 2 * vp_w, x0, x1);
        if (ok) ok = fit_axis(ay, int'(r.h), gv, 2 * vp_h, y0, y1);
        if (!ok)
        begin
            p.status = STS_OUTSIDE;
            return p;
        end
        nx = tiles_of(vp_w, NTX);
        ny = tiles_of(vp_h, NTY);
        tx0 = x0 / (2 * TSIZE);
        tx1 = (x1 + 2 * TSIZE - 1) / (2 * TSIZE);
        ty0 = y0 / (2 * TSIZE);
        ty1 = (y1 + 2 * TSIZE - 1) / (2 * TSIZE);
        if (tx0 > nx || ty0 > ny)
        begin
            p.status = STS_OUTSIDE;
            return p;
        end
        if (tx1 >= nx) tx1 = nx - 1;
        if (ty1 >= ny) ty1 = ny - 1;
        p.xmin = COORD_W'(x0);
        p.xmax = COORD_W'(x1);
        p.ymin = COORD_W'(y0);
        p.ymax = COORD_W'(y1);
        fd = 20;
        for (int tx = tx0; tx <= tx1; tx++)
            for (int ty = ty0; ty <= ty1; ty++)
            begin
                t = ty * NTX + tx;
                for (int k = 0; k < occupancy[t] && k < NBOX; k++)
                begin
                    d0 = box_x0[t][k] - x1;
                    d1 = x0 - box_x1[t][k];
                    d2 = box_y0[t][k] - y1;
                    d3 = y0 - box_y1[t][k];
                    if (d0 < 0 && d1 < 0 && d2 < 0 && d3 < 0)
                    begin
                        p.status = STS_OVERLAP;
                        return p;
                    end
                    d0 = gap_of(d0);
                    d1 = gap_of(d1);
                    d2 = gap_of(d2);
                    d3 = gap_of(d3);
                    ex = d0 < d1 ? d0 : d1;
                    ey = d2 < d3 ? d2 : d3;
                    if (ex < 20 && ey < 20)
                    begin
                        if (ex < fd) fd = ex;
                        if (ey < fd) fd = ey;
                    end
                end
            end
        for (int tx = tx0; tx <= tx1; tx++)
            for (int ty = ty0; ty <= ty1; ty++)
                if (occupancy[ty * NTX + tx] >= NBOX)
                begin
                    p.status = STS_FULL;
                    return p;
                end
        for (int tx = tx0; tx <= tx1; tx++)
            for (int ty = ty0; ty <= ty1; ty++)
            begin
                t = ty * NTX + tx;
                box_x0[t][occupancy[t]] = x0;
                box_x1[t][occupancy[t]] = x1;
                box_y0[t][occupancy[t]] = y0;
                box_y1[t][occupancy[t]] = y1;
                occupancy[t]++;
            end
        p.status = STS_PLACED;
        p.fade = FADE_W'(fd);
        return p;
    endfunction

    task automatic write_reg(cfg_index_t idx, int val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ORIGIN_X: org_x = val & 'h1fff;
            CFG_ORIGIN_Y: org_y = val & 'h1fff;
            CFG_VP_W:     vp_w = val & 'hfff;
            CFG_VP_H:     vp_h = val & 'hfff;
            CFG_ALIGN_H:  grav_h = val & 3;
            CFG_ALIGN_V:  grav_v = val & 3;
            default:      ;
        endcase
    endtask

    task automatic settle();
        while (pending_q.size() != 0) @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic send_label(label_req_t r, logic has_exp, placement_t e);
        placement_t p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            place.valid = 1'b0;
            @(negedge clk);
        end
        place.valid = 1'b1;
        {place.kind, place.anchor_x, place.anchor_y, place.label_width,
         place.label_height, place.is_icon} = r;
        @(posedge clk);
        while (!place.ready) @(posedge clk);
        p = place_label(r);
        pending_q = {pending_q, p};
        forced_valid_q = {forced_valid_q, has_exp};
        forced_q = {forced_q, e};
        @(negedge clk);
        place.valid = 1'b0;
    endtask

    function automatic label_req_t random_label();
        label_req_t r;
        int sel;
        r.kind = ($urandom_range(99) < 3);
        r.icon = 1'($urandom_range(1));
        sel = int'($urandom_range(99));
        if (sel < 80)
        begin
            r.ax = ANCH_W'(org_x + int'($urandom_range(vp_w + 20)) - 10);
            r.ay = ANCH_W'(org_y + int'($urandom_range(vp_h + 20)) - 10);
            r.w = SIZE_W'($urandom_range(40));
            r.h = SIZE_W'($urandom_range(40));
        end
        else
        begin
            r.ax = ANCH_W'($urandom_range(16383));
            r.ay = ANCH_W'($urandom_range(16383));
            r.w = SIZE_W'($urandom_range(2047));
            r.h = SIZE_W'($urandom_range(2047));
        end
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            result.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            result.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        placement_t got, want, typed;
        logic forced;
        if (rst_n && result.valid && result.ready)
        begin
            got = {result.status, result.fade, result.box_xmin, result.box_xmax,
                   result.box_ymin, result.box_ymax};
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                forced = forced_valid_q.pop_front();
                typed = forced_q.pop_front();
                if (forced && typed != want)
                begin
                    $display("%0t: table row expected %h, predictor %h", $time, typed, want);
                    errors++;
                end
                check_field("status", int'(want.status), int'(got.status));
                check_field("fade", int'(want.fade), int'(got.fade));
                check_field("xmin", int'(want.xmin), int'(got.xmin));
                check_field("xmax", int'(want.xmax), int'(got.xmax));
                check_field("ymin", int'(want.ymin), int'(got.ymin));
                check_field("ymax", int'(want.ymax), int'(got.ymax));
            end
        end
    end

    vector_t directed [$];

    function automatic vector_t row(logic k, int ax, int ay, int w, int h, logic icon,
                                    logic has, placement_t e);
        vector_t v;
        v.req.kind = k;
        v.req.ax = ANCH_W'(ax);
        v.req.ay = ANCH_W'(ay);
        v.req.w = SIZE_W'(w);
        v.req.h = SIZE_W'(h);
        v.req.icon = icon;
        v.has_exp = has;
        v.exp = e;
        return v;
    endfunction

    initial
    begin
        int phase;
        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        place.valid = 1'b0;
        place.kind = 1'b0;
        place.anchor_x = '0;
        place.anchor_y = '0;
        place.label_width = '0;
        place.label_height = '0;
        place.is_icon = 1'b0;
        result.ready = 1'b1;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        org_x = 0; org_y = 0; vp_w = 2048; vp_h = 2048; grav_h = 1; grav_v = 1;
        foreach (occupancy[i]) occupancy[i] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed = {directed, row(1'b1, 0, 0, 0, 0, 1'b0, 1'b1,
                                  {STS_CLEARED, 5'd0, 52'd0})};
        directed = {directed, row(1'b0, -4096, -4096, 0, 0, 1'b0, 1'b1,
                                  {STS_OUTSIDE, 5'd0, 52'd0})};
        directed = {directed, row(1'b0, 8191, 8191, 2047, 2047, 1'b1, 1'b1,
                                  {STS_OUTSIDE, 5'd0, 52'd0})};
        directed = {directed, row(1'b0, 0, 0, 10, 10, 1'b0, 1'b1,
                                  {STS_PLACED, 5'd20, 13'd0, 13'd20, 13'd0, 13'd20})};
        directed = {directed, row(1'b0, 5, 5, 10, 10, 1'b0, 1'b1,
                                  {STS_OVERLAP, 5'd0, 13'd10, 13'd30, 13'd10, 13'd30})};
        directed = {directed, row(1'b0, 10, 0, 10, 10, 1'b0, 1'b0, '0)};
        directed = {directed, row(1'b0, 25, 25, 4, 4, 1'b1, 1'b0, '0)};
        directed = {directed, row(1'b0, 2048, 2048, 2047, 2047, 1'b1, 1'b0, '0)};
        directed = {directed, row(1'b0, 1920, 100, 5, 5, 1'b0, 1'b0, '0)};
        directed = {directed, row(1'b0, 1000, 1000, 2047, 2047, 1'b1, 1'b0, '0)};
        directed = {directed, row(1'b0, 8191, -4096, 2047, 0, 1'b1, 1'b0, '0)};
        for (int i = 0; i < 12; i++)
            directed = {directed, row(1'b0, 300 + 3 * i, 300, 1, 1, 1'b0, 1'b0, '0)};
        directed = {directed, row(1'b1, 0, 0, 0, 0, 1'b1, 1'b1,
                                  {STS_CLEARED, 5'd0, 52'd0})};
        foreach (directed[i]) send_label(directed[i].req, directed[i].has_exp, directed[i].exp);
        settle();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_ALIGN_H, 0);
                    write_reg(CFG_ALIGN_V, 0);
                end
                1:
                begin
                    write_reg(CFG_ALIGN_H, 2);
                    write_reg(CFG_ALIGN_V, 2);
                end
                2:
                begin
                    write_reg(CFG_VP_W, 1);
                    write_reg(CFG_VP_H, 1);
                end
                3:
                begin
                    write_reg(CFG_ORIGIN_X, 8191);
                    write_reg(CFG_ORIGIN_Y, 8191);
                    write_reg(CFG_VP_W, 2048);
                    write_reg(CFG_VP_H, 2048);
                end
                4:
                begin
                    write_reg(CFG_ORIGIN_X, 100);
                    write_reg(CFG_ORIGIN_Y, 0);
                    write_reg(CFG_VP_W, 500);
                    write_reg(CFG_VP_H, 300);
                    write_reg(CFG_ALIGN_H, 3);
                    write_reg(CFG_ALIGN_V, 1);
                end
                5:
                begin
                    write_reg(CFG_ORIGIN_X, 0);
                    write_reg(CFG_VP_W, 0);
                    write_reg(CFG_VP_H, 4095);
                end
                6:
                begin
                    write_reg(CFG_VP_W, 640);
                    write_reg(CFG_VP_H, 480);
                end
                default:
                begin
                    write_reg(CFG_VP_W, 2048);
                    write_reg(CFG_VP_H, 2048);
                    write_reg(CFG_ALIGN_H, 1);
                end
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct = 30;
                    recv_stall_pct = 30;
                end
            endcase
            if (phase == 2) hold_off = 400;
            for (int i = 0; i < 225; i++)
                send_label(random_label(), 1'b0, '0);
            settle();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tlcp_pkg.sv
rtl/tlcp_if.sv
rtl/tlcp_ram.sv
rtl/tlcp_align.sv
rtl/tlcp_gap.sv
rtl/tiled_label_collision_placer.sv
dv/tb_tiled_label_collision_placer.sv
